### rtl/coalesced_hash_table_macros.svh
// assertion macros shared by the hash table rtl
`ifndef COALESCED_HASH_TABLE_MACROS_SVH
`define COALESCED_HASH_TABLE_MACROS_SVH

// checked on every clock edge outside reset
`define CHT_CHECK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked on every clock edge, reset included
`define CHT_CHECK_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

### rtl/cht_pkg.sv
// shared types and constants of the coalesced hash table
package cht_pkg;

  localparam int unsigned KEY_W         = 31;
  localparam int unsigned STATUS_W      = 3;
  localparam int unsigned SLOT_W        = 7;
  localparam int unsigned CFG_W         = 8;
  localparam int unsigned DEFAULT_DEPTH = 128;
  localparam logic [CFG_W-1:0] CFG_RESET = 8'd128;

  typedef enum logic {
    CMD_INSERT = 1'b0,
    CMD_LOOKUP = 1'b1
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED  = 3'd0,
    ST_DUPLICATE = 3'd1,
    ST_FULL      = 3'd2,
    ST_FOUND     = 3'd3,
    ST_NOT_FOUND = 3'd4
  } status_e;

  typedef struct packed {
    cmd_e             cmd;
    logic [KEY_W-1:0] key;
  } req_t;

  typedef struct packed {
    status_e           status;
    logic [SLOT_W-1:0] slot;
  } rsp_t;

endpackage

### rtl/cht_modulo.sv
// bit-serial restoring remainder of a key by the table size
module cht_modulo #(
  parameter int unsigned DW = 8
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [cht_pkg::KEY_W-1:0]   dividend_i,
  input  logic [DW-1:0]               divisor_i,
  output logic                        done_o,
  output logic [DW-1:0]               rem_o
);

  localparam int unsigned CNT_W = $clog2(cht_pkg::KEY_W + 1);

  logic                        busy_q, busy_d;
  logic                        done_q, done_d;
  logic [CNT_W-1:0]            cnt_q, cnt_d;
  logic [cht_pkg::KEY_W-1:0]   shr_q, shr_d;
  logic [DW-1:0]               rem_q, rem_d;
  logic [DW-1:0]               div_q, div_d;
  logic [DW:0]                 trial;

  assign trial = {rem_q, shr_q[cht_pkg::KEY_W-1]};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    shr_d  = shr_q;
    rem_d  = rem_q;
    div_d  = div_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(cht_pkg::KEY_W);
      shr_d  = dividend_i;
      rem_d  = '0;
      div_d  = divisor_i;
    end else if (busy_q) begin
      // one quotient bit per cycle, msb first
      if (trial >= {1'b0, div_q}) begin
        rem_d = DW'(trial - {1'b0, div_q});
      end else begin
        rem_d = trial[DW-1:0];
      end
      shr_d = {shr_q[cht_pkg::KEY_W-2:0], 1'b0};
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    shr_q <= shr_d;
    rem_q <= rem_d;
    div_q <= div_d;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

### rtl/coalesced_hash_table.sv
// coalesced-chaining hash table of 31-bit keys, top level
//
// One command at a time: pulse start while busy is low with an insert or a
// lookup; exactly one result comes back on rsp_o for a single cycle with
// done_o high, and the receiver must take it then since it cannot stall.
// A new command is taken in the same cycle that a result is shown. After
// reset the block runs a clearing pass over all TABLE_DEPTH slots of the slot
// memory and holds busy high; table size writes are taken during it.
// Steps per command, with n the effective table size: the bit-serial
// remainder finds the home slot, then a lookup reads and checks each chain
// entry in turn, and an insert runs a pipelined duplicate and free-slot
// scan of the n slots and a decision that ends on a duplicate, a full table
// or an empty home slot (written at once), else walks the chain to the tail
// with one read and one check per entry and makes two writes. The slot
// memory's separate read and write ports and registered read set this pace.
`include "coalesced_hash_table_macros.svh"

module coalesced_hash_table #(
  parameter int unsigned TABLE_DEPTH = cht_pkg::DEFAULT_DEPTH
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // command channel
  input  logic                      start,
  output logic                      busy,
  input  cht_pkg::req_t             req_i,
  // result channel
  output logic                      done_o,
  output cht_pkg::rsp_t             rsp_o,
  // table size register
  input  logic                      cfg_we_i,
  input  logic [cht_pkg::CFG_W-1:0] cfg_wdata_i
);

  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  // wide enough to hold the depth itself; all ones marks the null link
  localparam int unsigned NW = AW + 1;
  localparam int unsigned CW = (NW > cht_pkg::CFG_W) ? NW : cht_pkg::CFG_W;
  localparam logic [NW-1:0] NULL_LINK = '1;

  localparam logic [3:0] S_CLEAR    = 4'd0;
  localparam logic [3:0] S_IDLE     = 4'd1;
  localparam logic [3:0] S_MOD      = 4'd2;
  localparam logic [3:0] S_SCAN     = 4'd3;
  localparam logic [3:0] S_DECIDE   = 4'd4;
  localparam logic [3:0] S_WALK_RD  = 4'd5;
  localparam logic [3:0] S_WALK_CHK = 4'd6;
  localparam logic [3:0] S_LINK     = 4'd7;
  localparam logic [3:0] S_FILL     = 4'd8;
  localparam logic [3:0] S_LK_RD    = 4'd9;
  localparam logic [3:0] S_LK_CHK   = 4'd10;

  typedef struct packed {
    logic                      valid;
    logic [NW-1:0]             next;
    logic [cht_pkg::KEY_W-1:0] key;
  } entry_t;

  // slot memory: one word per slot holding valid, link and key
  entry_t mem [TABLE_DEPTH];
  entry_t rd_q;
  logic [AW-1:0] raddr;
  logic          mem_we;
  logic [AW-1:0] waddr;
  entry_t        wdata;

  logic [3:0]                state_q, state_d;
  logic [cht_pkg::CFG_W-1:0] size_q;
  logic [NW-1:0]             n_eff;
  logic                      accept;

  logic [AW-1:0]             clr_q, clr_d;
  cht_pkg::cmd_e             cmd_q, cmd_d;
  logic [cht_pkg::KEY_W-1:0] key_q, key_d;
  logic [NW-1:0]             n_q, n_d;
  logic [AW-1:0]             home_q, home_d;
  logic [NW-1:0]             scan_q, scan_d;
  logic                      pend_q, pend_d;
  logic [AW-1:0]             pidx_q, pidx_d;
  logic                      dup_q, dup_d;
  logic                      home_vld_q, home_vld_d;
  logic                      free_fnd_q, free_fnd_d;
  logic [AW-1:0]             free_q, free_d;
  logic [AW-1:0]             cur_q, cur_d;
  logic [AW-1:0]             steps_q, steps_d;
  logic                      last_q, last_d;
  logic [AW-1:0]             tail_q, tail_d;
  entry_t                    tail_word_q, tail_word_d;
  cht_pkg::rsp_t             rsp_q, rsp_d;
  logic                      done_q, done_d;

  logic                      mod_done;
  logic [NW-1:0]             mod_rem;
  logic                      lk_rsp;

  // table size in effect: zero reads as one, above the depth as the depth
  always_comb begin
    if (size_q == '0) begin
      n_eff = NW'(1);
    end else if (CW'(size_q) > CW'(TABLE_DEPTH)) begin
      n_eff = NW'(TABLE_DEPTH);
    end else begin
      n_eff = NW'(size_q);
    end
  end

  assign accept = start && (state_q == S_IDLE);
  assign busy   = (state_q != S_IDLE);

  cht_modulo #(
    .DW (NW)
  ) u_modulo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (accept),
    .dividend_i (req_i.key),
    .divisor_i  (n_eff),
    .done_o     (mod_done),
    .rem_o      (mod_rem)
  );

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    cmd_d       = cmd_q;
    key_d       = key_q;
    n_d         = n_q;
    home_d      = home_q;
    scan_d      = scan_q;
    pend_d      = 1'b0;
    pidx_d      = pidx_q;
    dup_d       = dup_q;
    home_vld_d  = home_vld_q;
    free_fnd_d  = free_fnd_q;
    free_d      = free_q;
    cur_d       = cur_q;
    steps_d     = steps_q;
    last_d      = last_q;
    tail_d      = tail_q;
    tail_word_d = tail_word_q;
    rsp_d       = rsp_q;
    done_d      = 1'b0;
    raddr       = cur_q;
    mem_we      = 1'b0;
    waddr       = cur_q;
    wdata       = '{valid: 1'b1, next: NULL_LINK, key: key_q};

    unique case (state_q)
      S_CLEAR: begin
        mem_we = 1'b1;
        waddr  = clr_q;
        wdata  = '{valid: 1'b0, next: NULL_LINK, key: '0};
        clr_d  = clr_q + AW'(1);
        if (clr_q == AW'(TABLE_DEPTH - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          cmd_d   = req_i.cmd;
          key_d   = req_i.key;
          n_d     = n_eff;
          state_d = S_MOD;
        end
      end
      S_MOD: begin
        if (mod_done) begin
          // remainder is below the size, so it fits a slot index
          home_d  = mod_rem[AW-1:0];
          cur_d   = mod_rem[AW-1:0];
          steps_d = '0;
          last_d  = 1'b0;
          if (cmd_q == cht_pkg::CMD_INSERT) begin
            scan_d     = '0;
            dup_d      = 1'b0;
            home_vld_d = 1'b0;
            free_fnd_d = 1'b0;
            state_d    = S_SCAN;
          end else begin
            state_d = S_LK_RD;
          end
        end
      end
      S_SCAN: begin
        // issue slot scan_q, check the slot read in the previous cycle
        if (scan_q < n_q) begin
          raddr  = scan_q[AW-1:0];
          scan_d = scan_q + NW'(1);
          pend_d = 1'b1;
          pidx_d = scan_q[AW-1:0];
        end
        if (pend_q) begin
          if (rd_q.valid && (rd_q.key == key_q)) begin
            dup_d = 1'b1;
          end
          if (!rd_q.valid && !free_fnd_q) begin
            free_fnd_d = 1'b1;
            free_d     = pidx_q;
          end
          if (pidx_q == home_q) begin
            home_vld_d = rd_q.valid;
          end
        end
        if ((scan_q >= n_q) && !pend_q) begin
          state_d = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (dup_q) begin
          rsp_d   = '{status: cht_pkg::ST_DUPLICATE, slot: '0};
          done_d  = 1'b1;
          state_d = S_IDLE;
        end else if (!home_vld_q) begin
          mem_we  = 1'b1;
          waddr   = home_q;
          rsp_d   = '{status: cht_pkg::ST_INSERTED, slot: cht_pkg::SLOT_W'(home_q)};
          done_d  = 1'b1;
          state_d = S_IDLE;
        end else if (!free_fnd_q) begin
          rsp_d   = '{status: cht_pkg::ST_FULL, slot: '0};
          done_d  = 1'b1;
          state_d = S_IDLE;
        end else begin
          state_d = S_WALK_RD;
        end
      end
      S_WALK_RD: begin
        state_d = S_WALK_CHK;
      end
      S_WALK_CHK: begin
        // a link at or past the size ends the chain
        if (last_q || (rd_q.next >= n_q)) begin
          tail_d      = cur_q;
          tail_word_d = rd_q;
          state_d     = S_LINK;
        end else begin
          cur_d   = rd_q.next[AW-1:0];
          steps_d = steps_q + AW'(1);
          if (steps_q == AW'(TABLE_DEPTH - 1)) begin
            last_d = 1'b1;
          end
          state_d = S_WALK_RD;
        end
      end
      S_LINK: begin
        mem_we  = 1'b1;
        waddr   = tail_q;
        wdata   = '{valid: tail_word_q.valid, next: NW'(free_q), key: tail_word_q.key};
        state_d = S_FILL;
      end
      S_FILL: begin
        mem_we  = 1'b1;
        waddr   = free_q;
        rsp_d   = '{status: cht_pkg::ST_INSERTED, slot: cht_pkg::SLOT_W'(free_q)};
        done_d  = 1'b1;
        state_d = S_IDLE;
      end
      S_LK_RD: begin
        state_d = S_LK_CHK;
      end
      S_LK_CHK: begin
        if (rd_q.valid && (rd_q.key == key_q)) begin
          rsp_d   = '{status: cht_pkg::ST_FOUND, slot: cht_pkg::SLOT_W'(cur_q)};
          done_d  = 1'b1;
          state_d = S_IDLE;
        end else if ((rd_q.next >= n_q) || (steps_q == AW'(TABLE_DEPTH - 1))) begin
          // an empty home slot also lands here, its link is null
          rsp_d   = '{status: cht_pkg::ST_NOT_FOUND, slot: '0};
          done_d  = 1'b1;
          state_d = S_IDLE;
        end else begin
          cur_d   = rd_q.next[AW-1:0];
          steps_d = steps_q + AW'(1);
          state_d = S_LK_RD;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // slot memory with registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[waddr] <= wdata;
    end
    rd_q <= mem[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q   <= '0;
      size_q  <= cht_pkg::CFG_RESET;
      pend_q  <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      pend_q  <= pend_d;
      done_q  <= done_d;
      if (cfg_we_i) begin
        size_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q       <= cmd_d;
    key_q       <= key_d;
    n_q         <= n_d;
    home_q      <= home_d;
    scan_q      <= scan_d;
    pidx_q      <= pidx_d;
    dup_q       <= dup_d;
    home_vld_q  <= home_vld_d;
    free_fnd_q  <= free_fnd_d;
    free_q      <= free_d;
    cur_q       <= cur_d;
    steps_q     <= steps_d;
    last_q      <= last_d;
    tail_q      <= tail_d;
    tail_word_q <= tail_word_d;
    rsp_q       <= rsp_d;
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  // result transfer carrying a lookup outcome
  assign lk_rsp = done_o && ((rsp_o.status == cht_pkg::ST_FOUND) ||
                             (rsp_o.status == cht_pkg::ST_NOT_FOUND));

  // a result transfer is shown only once the block has gone idle
  `CHT_CHECK(a_done_idle, done_o |-> !busy, "result shown while busy")
  // the slot memory is never written while idle
  `CHT_CHECK_ALWAYS(a_no_idle_write, (state_q == S_IDLE) |-> !mem_we, "memory write while idle")
  // lookup outcomes belong to lookups only
  `CHT_CHECK(a_lookup_status, lk_rsp |-> (cmd_q == cht_pkg::CMD_LOOKUP), "lookup status on insert")
  // the remainder unit finishes only while the sequencer waits for it
  `CHT_CHECK(a_mod_wait, mod_done |-> (state_q == S_MOD), "remainder done outside wait")

endmodule
